// ===== src/hcc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the hum comb canceller.
// No dependencies; every other file but hcc_ram and hcc_queue imports this package.
package hcc_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned STORE_W  = 16;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned RATE_W   = 32;
  localparam int unsigned PWM_W    = 8;
  localparam int unsigned CORR_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Lag distance of the correlations and the shortest period
  localparam int unsigned LAG        = 2;
  localparam int unsigned MIN_PERIOD = 8;

  localparam logic [STORE_W-1:0]  STORE_INIT = 16'h8000;
  localparam logic [RATE_W-1:0]   RESET_RATE = 32'hFFFF_FFFF;
  localparam logic [RATE_W-1:0]   BIG_STEP   = 32'd200;
  localparam logic [RATE_W-1:0]   SMALL_STEP = 32'd10;
  localparam logic [SAMPLE_W-1:0] CLIP_LOW   = 10'd20;
  localparam logic [SAMPLE_W-1:0] CLIP_HIGH  = 10'd1003;
  localparam logic [SHIFT_W-1:0]  FRAC_BITS  = 3'd6;
  localparam logic [SHIFT_W-1:0]  SHIFT_CAP  = 3'd6;
  localparam logic signed [11:0]  PWM_OFFSET = 12'sd512;

  localparam logic                 RST_SUBTRACT_MODE = 1'b1;
  localparam logic [SHIFT_W-1:0]   RST_MAX_SHIFT     = 3'd6;
  localparam logic [PERIOD_W-1:0]  RST_PERIOD_LENGTH = 10'd400;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBTRACT_MODE = 2'd0,
    REG_MAX_SHIFT     = 2'd1,
    REG_PERIOD_LENGTH = 2'd2,
    REG_INITIAL_RATE  = 2'd3
  } hcc_cfg_reg_e;

  typedef enum logic [1:0] {
    ADJ_BIG_UP     = 2'd0,
    ADJ_BIG_DOWN   = 2'd1,
    ADJ_SMALL_UP   = 2'd2,
    ADJ_SMALL_DOWN = 2'd3
  } hcc_adj_e;

  // One classified sample with the store words read for it
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                period_end;
    logic                in_window;
    logic [STORE_W-1:0]  center_word;
    logic [STORE_W-1:0]  after_word;
  } hcc_item_t;

endpackage

// ===== src/hcc_ram.sv =====
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module hcc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic                     re_b_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== src/hcc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, tracks the period position, issues store reads
// and runs the store clearing sweep after reset. Depends on hcc_pkg.
module hcc_front
  import hcc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [PERIOD_W-1:0]            period_length_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [SAMPLE_W-1:0]            sample_i,
  output logic                           rd_en_o,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr_center_o,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr_after_o,
  input  logic [STORE_W-1:0]             rd_data_center_i,
  input  logic [STORE_W-1:0]             rd_data_after_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output hcc_item_t                      push_item_o,
  output logic [$clog2(STORE_DEPTH)-1:0] push_addr_o,
  output logic                           clr_we_o,
  output logic [$clog2(STORE_DEPTH)-1:0] clr_addr_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned LW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW = (LW > PERIOD_W) ? LW : PERIOD_W;
  localparam int unsigned EW = CW + 1;

  logic [CW-1:0] len_raw;
  logic [CW-1:0] eff_len;
  logic [EW-1:0] pos_ext;
  logic          period_end;
  logic          in_window;
  logic          accept;
  logic          push;

  logic [AW-1:0]       pos_q,       pos_d;
  logic                rs_valid_q,  rs_valid_d;
  logic [SAMPLE_W-1:0] rs_sample_q;
  logic                rs_end_q;
  logic                rs_win_q;
  logic [AW-1:0]       rs_addr_q;
  logic                clr_busy_q,  clr_busy_d;
  logic [AW-1:0]       clr_addr_q,  clr_addr_d;

  // Clamp the period into the legal range of the store
  always_comb begin
    len_raw = CW'(period_length_i);
    if (len_raw < CW'(MIN_PERIOD)) begin
      eff_len = CW'(MIN_PERIOD);
    end else if (len_raw > CW'(STORE_DEPTH)) begin
      eff_len = CW'(STORE_DEPTH);
    end else begin
      eff_len = len_raw;
    end
  end

  assign pos_ext    = EW'(pos_q);
  assign period_end = (pos_ext + EW'(1)) >= EW'(eff_len);
  assign in_window  = (pos_ext >= EW'(LAG)) && ((pos_ext + EW'(LAG)) < EW'(eff_len));

  assign in_ready_o = !clr_busy_q && (!rs_valid_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign push       = rs_valid_q && push_ready_i;

  assign rd_en_o          = accept;
  assign rd_addr_center_o = pos_q;
  assign rd_addr_after_o  = pos_q + AW'(LAG);

  assign push_valid_o = rs_valid_q;
  assign push_addr_o  = rs_addr_q;
  always_comb begin
    push_item_o.sample      = rs_sample_q;
    push_item_o.period_end  = rs_end_q;
    push_item_o.in_window   = rs_win_q;
    push_item_o.center_word = rd_data_center_i;
    push_item_o.after_word  = rd_data_after_i;
  end

  assign clr_we_o   = clr_busy_q;
  assign clr_addr_o = clr_addr_q;

  always_comb begin
    pos_d      = pos_q;
    rs_valid_d = rs_valid_q;
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (push) begin
      rs_valid_d = 1'b0;
    end
    if (accept) begin
      rs_valid_d = 1'b1;
      pos_d      = period_end ? '0 : pos_q + AW'(1);
    end
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(STORE_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      rs_valid_q <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      pos_q      <= pos_d;
      rs_valid_q <= rs_valid_d;
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rs_sample_q <= sample_i;
      rs_end_q    <= period_end;
      rs_win_q    <= in_window;
      rs_addr_q   <= pos_q;
    end
  end

endmodule

// ===== src/hcc_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO between front end and back end.
// No dependencies.
module hcc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q,  count_d;
  logic             push;
  logic             pop;

  assign push_ready_o = count_q != NW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + NW'(1);
    end else if (pop && !push) begin
      count_d = count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/hcc_back.sv =====
`timescale 1ns / 1ps
// Back end: updates the averaged waveform, accumulates lag correlations,
// adjusts the rate word at period end and holds the result. Depends on hcc_pkg.
module hcc_back
  import hcc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           subtract_mode_i,
  input  logic [SHIFT_W-1:0]             max_shift_i,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  hcc_item_t                      pop_item_i,
  input  logic [$clog2(STORE_DEPTH)-1:0] pop_addr_i,
  output logic                           wr_en_o,
  output logic [$clog2(STORE_DEPTH)-1:0] wr_addr_o,
  output logic [STORE_W-1:0]             wr_data_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [PWM_W-1:0]               pwm_value_o,
  output logic [SAMPLE_W-1:0]            smoothed_o,
  output logic                           period_end_o,
  output logic [1:0]                     adjust_code_o,
  output logic                           clip_flag_o,
  output logic [RATE_W-1:0]              sample_rate_o
);

  logic                  pop;
  logic [SAMPLE_W-1:0]   val;
  logic                  clip_hit;
  logic [7:0]            v8;
  logic [15:0]           prod_c, prod_b, prod_a;
  logic [STORE_W-1:0]    w_dec, w_add, w_new;
  logic [SHIFT_W-1:0]    cap;
  logic signed [11:0]    diff;
  logic [PWM_W-1:0]      pwm;
  hcc_adj_e              code;
  logic [RATE_W-1:0]     rate_adj;

  logic                  out_valid_q,  out_valid_d;
  logic [SHIFT_W-1:0]    shift_q,      shift_d;
  logic [CORR_W-1:0]     corr_c_q,     corr_c_d;
  logic [CORR_W-1:0]     corr_b_q,     corr_b_d;
  logic [CORR_W-1:0]     corr_a_q,     corr_a_d;
  logic [SAMPLE_W-1:0]   prev_sample_q, prev_sample_d;
  logic [SAMPLE_W-1:0]   prev_smooth_q, prev_smooth_d;
  logic                  clip_seen_q,  clip_seen_d;
  logic [RATE_W-1:0]     rate_q,       rate_d;
  logic [STORE_W-1:0]    w1_q, w2_q;
  logic [PWM_W-1:0]      out_pwm_q;
  logic                  out_end_q;
  hcc_adj_e              out_code_q;
  logic                  out_clip_q;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  assign val      = pop_item_i.sample;
  assign clip_hit = (val < CLIP_LOW) || (val > CLIP_HIGH);
  assign v8       = val[SAMPLE_W-1:2];

  // The entry two positions back was written by the item two beats earlier
  assign prod_c = 16'(v8) * 16'(pop_item_i.center_word[15:8]);
  assign prod_b = 16'(v8) * 16'(w2_q[15:8]);
  assign prod_a = 16'(v8) * 16'(pop_item_i.after_word[15:8]);

  assign w_dec = pop_item_i.center_word - (pop_item_i.center_word >> shift_q);
  assign w_add = STORE_W'(val) << (FRAC_BITS - shift_q);
  assign w_new = w_dec + w_add;

  assign cap = (max_shift_i > SHIFT_CAP) ? SHIFT_CAP : max_shift_i;

  always_comb begin
    diff = $signed({2'b00, prev_sample_q}) - $signed({2'b00, prev_smooth_q}) + PWM_OFFSET;
    if (!subtract_mode_i) begin
      pwm = prev_smooth_q[SAMPLE_W-1:2];
    end else if (diff[11]) begin
      pwm = '0;
    end else if (diff[11:2] > 10'd255) begin
      pwm = '1;
    end else begin
      pwm = diff[9:2];
    end
  end

  always_comb begin
    if (corr_b_q > corr_c_q) begin
      code     = ADJ_BIG_UP;
      rate_adj = rate_q + BIG_STEP;
    end else if (corr_a_q > corr_c_q) begin
      code     = ADJ_BIG_DOWN;
      rate_adj = rate_q - BIG_STEP;
    end else if (corr_b_q > corr_a_q) begin
      code     = ADJ_SMALL_UP;
      rate_adj = rate_q + SMALL_STEP;
    end else begin
      code     = ADJ_SMALL_DOWN;
      rate_adj = rate_q - SMALL_STEP;
    end
  end

  always_comb begin
    out_valid_d   = out_valid_q;
    shift_d       = shift_q;
    corr_c_d      = corr_c_q;
    corr_b_d      = corr_b_q;
    corr_a_d      = corr_a_q;
    prev_sample_d = prev_sample_q;
    prev_smooth_d = prev_smooth_q;
    clip_seen_d   = clip_seen_q;
    rate_d        = rate_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      out_valid_d   = 1'b1;
      prev_sample_d = val;
      prev_smooth_d = w_new[STORE_W-1:FRAC_BITS];
      clip_seen_d   = clip_seen_q | clip_hit;
      if (pop_item_i.in_window) begin
        corr_c_d = corr_c_q + CORR_W'(prod_c);
        corr_b_d = corr_b_q + CORR_W'(prod_b);
        corr_a_d = corr_a_q + CORR_W'(prod_a);
      end
      if (pop_item_i.period_end) begin
        clip_seen_d = 1'b0;
        corr_c_d    = '0;
        corr_b_d    = '0;
        corr_a_d    = '0;
        rate_d      = rate_adj;
        if (shift_q < cap) begin
          shift_d = shift_q + SHIFT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      shift_q       <= '0;
      corr_c_q      <= '0;
      corr_b_q      <= '0;
      corr_a_q      <= '0;
      prev_sample_q <= '0;
      prev_smooth_q <= '0;
      clip_seen_q   <= 1'b0;
      rate_q        <= RESET_RATE;
    end else begin
      out_valid_q   <= out_valid_d;
      shift_q       <= shift_d;
      corr_c_q      <= corr_c_d;
      corr_b_q      <= corr_b_d;
      corr_a_q      <= corr_a_d;
      prev_sample_q <= prev_sample_d;
      prev_smooth_q <= prev_smooth_d;
      clip_seen_q   <= clip_seen_d;
      rate_q        <= rate_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      w2_q       <= w1_q;
      w1_q       <= w_new;
      out_pwm_q  <= pwm;
      out_end_q  <= pop_item_i.period_end;
      out_code_q <= pop_item_i.period_end ? code : ADJ_BIG_UP;
      out_clip_q <= pop_item_i.period_end & (clip_seen_q | clip_hit);
    end
  end

  assign wr_en_o   = pop;
  assign wr_addr_o = pop_addr_i;
  assign wr_data_o = w_new;

  // Smoothed value and rate change only when a new result is loaded
  assign out_valid_o   = out_valid_q;
  assign pwm_value_o   = out_pwm_q;
  assign smoothed_o    = prev_smooth_q;
  assign period_end_o  = out_end_q;
  assign adjust_code_o = out_code_q;
  assign clip_flag_o   = out_clip_q;
  assign sample_rate_o = rate_q;

endmodule

// ===== src/hum_comb_canceller.sv =====
`timescale 1ns / 1ps
// Top level of the hum comb canceller: config registers, period store,
// front end, queue and back end. Depends on hcc_pkg and all hcc_* modules.
//
// Removes periodic mains hum from a stream of 10-bit samples. Every sample
// beat updates one entry of a per-period averaged waveform held in a
// STORE_DEPTH x 16 RAM and returns one result beat: a PWM byte (previous
// sample minus previous average, or the average alone), the smoothed value,
// and at the end of each period the rate adjust code, the clip flag and the
// updated 32-bit sample-rate word. The block sustains one sample per clock
// cycle while the output side is ready; each sample is registered in the
// front end with its store reads, passes the queue, and its result is
// registered in the back end. The rate rests on the two-port store read
// (current and lag-ahead entry) in the front end and the back end taking
// one item per update; the lag-behind entry comes from a two-deep history
// register. After reset the block clears the store to mid-scale in a sweep
// of one entry per cycle and holds in_ready_o low until the sweep is done;
// config writes are taken at any time. A write to initial_rate is taken but
// holds nothing: the rate word returns to a fixed default on every reset.
module hum_comb_canceller
  import hcc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SAMPLE_W-1:0]   sample_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PWM_W-1:0]      pwm_value_o,
  output logic [SAMPLE_W-1:0]   smoothed_o,
  output logic                  period_end_o,
  output logic [1:0]            adjust_code_o,
  output logic                  clip_flag_o,
  output logic [RATE_W-1:0]     sample_rate_o
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned QW = $bits(hcc_item_t) + AW;
  // Keep this short: a store entry is reread at least six beats after its
  // write, so no more than a few beats may wait between read and write.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Config registers
  logic                subtract_mode_q;
  logic [SHIFT_W-1:0]  max_shift_q;
  logic [PERIOD_W-1:0] period_length_q;

  // Store ports
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [STORE_W-1:0] ram_wdata;
  logic               rd_en;
  logic [AW-1:0]      rd_addr_center, rd_addr_after;
  logic [STORE_W-1:0] rd_data_center, rd_data_after;

  // Front end to queue
  logic       push_valid, push_ready;
  hcc_item_t  front_item;
  logic [AW-1:0] front_addr;
  logic       clr_we;
  logic [AW-1:0] clr_addr;

  // Queue to back end
  logic          pop_valid, pop_ready;
  logic [QW-1:0] pop_data;
  hcc_item_t     back_item;
  logic [AW-1:0] back_addr;
  logic          back_we;
  logic [AW-1:0] back_waddr;
  logic [STORE_W-1:0] back_wdata;

  // Config writes land on any cycle
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subtract_mode_q <= RST_SUBTRACT_MODE;
      max_shift_q     <= RST_MAX_SHIFT;
      period_length_q <= RST_PERIOD_LENGTH;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (hcc_cfg_reg_e'(cfg_index_i))
        REG_SUBTRACT_MODE: begin
          subtract_mode_q <= cfg_data_i[0];
        end
        REG_MAX_SHIFT: begin
          max_shift_q <= cfg_data_i[SHIFT_W-1:0];
        end
        REG_PERIOD_LENGTH: begin
          period_length_q <= cfg_data_i[PERIOD_W-1:0];
        end
        REG_INITIAL_RATE: begin
          // Reset value only; nothing to hold
        end
        default: begin
        end
      endcase
    end
  end

  // Clearing sweep owns the write port until it is done
  assign ram_we    = clr_we | back_we;
  assign ram_waddr = clr_we ? clr_addr : back_waddr;
  assign ram_wdata = clr_we ? STORE_INIT : back_wdata;

  hcc_ram #(
    .WIDTH (STORE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_a_i    (rd_en),
    .raddr_a_i (rd_addr_center),
    .rdata_a_o (rd_data_center),
    .re_b_i    (rd_en),
    .raddr_b_i (rd_addr_after),
    .rdata_b_o (rd_data_after)
  );

  hcc_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .period_length_i  (period_length_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .rd_en_o          (rd_en),
    .rd_addr_center_o (rd_addr_center),
    .rd_addr_after_o  (rd_addr_after),
    .rd_data_center_i (rd_data_center),
    .rd_data_after_i  (rd_data_after),
    .push_valid_o     (push_valid),
    .push_ready_i     (push_ready),
    .push_item_o      (front_item),
    .push_addr_o      (front_addr),
    .clr_we_o         (clr_we),
    .clr_addr_o       (clr_addr)
  );

  hcc_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({front_item, front_addr}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign back_item = hcc_item_t'(pop_data[QW-1:AW]);
  assign back_addr = pop_data[AW-1:0];

  hcc_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .subtract_mode_i (subtract_mode_q),
    .max_shift_i     (max_shift_q),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_item_i      (back_item),
    .pop_addr_i      (back_addr),
    .wr_en_o         (back_we),
    .wr_addr_o       (back_waddr),
    .wr_data_o       (back_wdata),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pwm_value_o     (pwm_value_o),
    .smoothed_o      (smoothed_o),
    .period_end_o    (period_end_o),
    .adjust_code_o   (adjust_code_o),
    .clip_flag_o     (clip_flag_o),
    .sample_rate_o   (sample_rate_o)
  );

`ifndef SYNTHESIS
  // The clearing sweep and the back end never both drive the store write
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_we |-> !back_we)
    else $error("store write from back end during clearing sweep");

  // No sample enters while the store is still being cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_we |-> !in_ready_o)
    else $error("sample accepted during clearing sweep");

  // Mid-period results carry no adjust code and no clip flag
  a_quiet_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !period_end_o) |-> (adjust_code_o == ADJ_BIG_UP && !clip_flag_o))
    else $error("adjust or clip reported outside a period end");

  // Every period end moves the rate word
  a_rate_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && back_item.period_end) |=>
      (sample_rate_o != $past(sample_rate_o)))
    else $error("period end left the rate word unchanged");
`endif

endmodule

// ===== sim/hcc_result_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the hum comb canceller: watches the config, sample and
// result channels, predicts every result beat and compares it. Needs hcc_pkg.
module hcc_result_checker
  import hcc_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 512
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PWM_W-1:0]      pwm_value_i,
  input  logic [SAMPLE_W-1:0]   smoothed_i,
  input  logic                  period_end_i,
  input  logic [1:0]            adjust_code_i,
  input  logic                  clip_flag_i,
  input  logic [RATE_W-1:0]     sample_rate_i,
  output int                    error_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [PWM_W-1:0]    pwm;
    logic [SAMPLE_W-1:0] smoothed;
    logic                period_end;
    hcc_adj_e            adjust;
    logic                clip;
    logic [RATE_W-1:0]   rate;
  } hum_result_t;

  // Config copy
  logic                subtract_q;
  logic [SHIFT_W-1:0]  max_shift_q;
  logic [PERIOD_W-1:0] period_q;

  // Filter state
  logic [STORE_W-1:0]  hum_store [STORE_DEPTH];
  int unsigned         pos_q;
  int unsigned         shift_q;
  logic [CORR_W-1:0]   corr_mid_q;
  logic [CORR_W-1:0]   corr_early_q;
  logic [CORR_W-1:0]   corr_late_q;
  logic [SAMPLE_W-1:0] last_sample_q;
  logic [SAMPLE_W-1:0] last_smooth_q;
  logic                clip_q;
  logic [RATE_W-1:0]   rate_q;

  hum_result_t         pending_results [$];
  hum_result_t         want;
  hum_result_t         got;
  hum_result_t         fresh;

  // Advance the averaged waveform by one sample and form its result beat.
  task automatic step_comb_filter(input logic [SAMPLE_W-1:0] smp, output hum_result_t res);
    int unsigned        len;
    int unsigned        cap;
    int unsigned        pos;
    int                 diff;
    logic               closing;
    logic [STORE_W-1:0] w;
    logic [CORR_W-1:0]  v8;
    logic [STORE_W-1:0] early_w;
    logic [STORE_W-1:0] late_w;
    len = period_q;
    if (len < MIN_PERIOD) len = MIN_PERIOD;
    if (len > STORE_DEPTH) len = STORE_DEPTH;
    cap = (max_shift_q > SHIFT_CAP) ? SHIFT_CAP : max_shift_q;
    pos = (pos_q >= STORE_DEPTH) ? 0 : pos_q;

    if (smp < CLIP_LOW || smp > CLIP_HIGH) clip_q = 1'b1;

    // Lag sums use the store as it was before this sample's update
    if (pos >= LAG && pos + LAG < len) begin
      v8 = CORR_W'(smp >> 2);
      w = hum_store[pos];
      early_w = hum_store[pos - LAG];
      late_w = hum_store[pos + LAG];
      corr_mid_q += v8 * CORR_W'(w[15:8]);
      corr_early_q += v8 * CORR_W'(early_w[15:8]);
      corr_late_q += v8 * CORR_W'(late_w[15:8]);
    end

    w = hum_store[pos];
    w = w - (w >> shift_q);
    w = w + (STORE_W'(smp) << (int'(FRAC_BITS) - int'(shift_q)));
    hum_store[pos] = w;

    closing = (pos + 1 >= len);
    if (closing) begin
      pos_q = 0;
      if (shift_q < cap) shift_q++;
    end else begin
      pos_q = pos + 1;
    end

    res = '0;
    if (subtract_q) begin
      diff = int'(last_sample_q) - int'(last_smooth_q) + 512;
      if (diff < 0) res.pwm = '0;
      else if (diff / 4 > 255) res.pwm = 8'hFF;
      else res.pwm = PWM_W'(diff / 4);
    end else begin
      res.pwm = last_smooth_q[9:2];
    end

    last_sample_q = smp;
    last_smooth_q = w[15:6];
    res.smoothed = w[15:6];
    res.period_end = closing;

    if (closing) begin
      res.clip = clip_q;
      clip_q = 1'b0;
      if (corr_early_q > corr_mid_q) begin
        res.adjust = ADJ_BIG_UP;
        rate_q += BIG_STEP;
      end else if (corr_late_q > corr_mid_q) begin
        res.adjust = ADJ_BIG_DOWN;
        rate_q -= BIG_STEP;
      end else if (corr_early_q > corr_late_q) begin
        res.adjust = ADJ_SMALL_UP;
        rate_q += SMALL_STEP;
      end else begin
        res.adjust = ADJ_SMALL_DOWN;
        rate_q -= SMALL_STEP;
      end
      corr_mid_q = '0;
      corr_early_q = '0;
      corr_late_q = '0;
    end
    res.rate = rate_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subtract_q = RST_SUBTRACT_MODE;
      max_shift_q = RST_MAX_SHIFT;
      period_q = RST_PERIOD_LENGTH;
      for (int i = 0; i < STORE_DEPTH; i++) hum_store[i] = STORE_INIT;
      pos_q = 0;
      shift_q = 0;
      corr_mid_q = '0;
      corr_early_q = '0;
      corr_late_q = '0;
      last_sample_q = '0;
      last_smooth_q = '0;
      clip_q = 1'b0;
      rate_q = RESET_RATE;
      pending_results.delete();
      error_count_o = 0;
      pending_o = 0;
    end else begin
      // The initial rate only matters at reset, so a write changes nothing
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SUBTRACT_MODE: subtract_q = cfg_data_i[0];
          REG_MAX_SHIFT:     max_shift_q = cfg_data_i[SHIFT_W-1:0];
          REG_PERIOD_LENGTH: period_q = cfg_data_i[PERIOD_W-1:0];
          REG_INITIAL_RATE:  ;
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        got.pwm = pwm_value_i;
        got.smoothed = smoothed_i;
        got.period_end = period_end_i;
        got.adjust = hcc_adj_e'(adjust_code_i);
        got.clip = clip_flag_i;
        got.rate = sample_rate_i;
        if (pending_results.size() == 0) begin
          error_count_o++;
          $display("%0t: result beat with nothing expected: pwm=%0d smoothed=%0d", $time,
                   got.pwm, got.smoothed);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            error_count_o++;
            $display({"%0t: result mismatch: expected pwm=%0d smoothed=%0d end=%0b adj=%0d ",
                      "clip=%0b rate=%h, actual pwm=%0d smoothed=%0d end=%0b adj=%0d ",
                      "clip=%0b rate=%h"}, $time,
                     want.pwm, want.smoothed, want.period_end, want.adjust, want.clip,
                     want.rate, got.pwm, got.smoothed, got.period_end, got.adjust, got.clip,
                     got.rate);
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        step_comb_filter(sample_i, fresh);
        pending_results.push_back(fresh);
      end
      pending_o = pending_results.size();
    end
  end

endmodule

// ===== sim/hum_comb_canceller_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the hum comb canceller: clock, reset, config writes and
// sample stimulus. Needs hcc_pkg, hum_comb_canceller and hcc_result_checker.
module hum_comb_canceller_tb;
  import hcc_pkg::*;

  localparam int unsigned STORE_DEPTH = 512;
  // Margin waited once every expected result beat has come back
  localparam int unsigned SETTLE_CYCLES = 6;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [PWM_W-1:0]      pwm_value_o;
  logic [SAMPLE_W-1:0]   smoothed_o;
  logic                  period_end_o;
  logic [1:0]            adjust_code_o;
  logic                  clip_flag_o;
  logic [RATE_W-1:0]     sample_rate_o;

  int fail_count;
  int results_pending;

  // Idle percentages of each side, changed as the run goes on
  int send_idle_pct = 35;
  int recv_idle_pct = 45;
  int samples_sent = 0;

  // Hum generator: a triangle of one period with drift and noise
  int hum_len;
  int hum_amp;
  int hum_offset;
  int hum_drift;
  int noise_amp;
  int phase_cnt;

  hum_comb_canceller #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pwm_value_o  (pwm_value_o),
    .smoothed_o   (smoothed_o),
    .period_end_o (period_end_o),
    .adjust_code_o(adjust_code_o),
    .clip_flag_o  (clip_flag_o),
    .sample_rate_o(sample_rate_o)
  );

  hcc_result_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pwm_value_i  (pwm_value_o),
    .smoothed_i   (smoothed_o),
    .period_end_i (period_end_o),
    .adjust_code_i(adjust_code_o),
    .clip_flag_i  (clip_flag_o),
    .sample_rate_i(sample_rate_o),
    .error_count_o(fail_count),
    .pending_o    (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: stall at random per cycle, changed on the falling edge
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Write one register; cfg_valid_i stays high so that writes can go back to back
  task automatic write_reg(input hcc_cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input logic mode, input logic [SHIFT_W-1:0] shift,
                               input logic [PERIOD_W-1:0] len, input logic [RATE_W-1:0] rate);
    write_reg(REG_SUBTRACT_MODE, CFG_DATA_W'(mode));
    write_reg(REG_MAX_SHIFT, CFG_DATA_W'(shift));
    write_reg(REG_PERIOD_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_INITIAL_RATE, rate);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one sample beat. Entered and left on a falling edge; valid is left
  // high so the next beat can follow without a gap.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    // First third: sender 35 / receiver 45, then swapped, then no idling
    if (samples_sent < 600) begin
      send_idle_pct = 35;
      recv_idle_pct = 45;
    end else if (samples_sent < 1200) begin
      send_idle_pct = 45;
      recv_idle_pct = 35;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // Drop valid and hold off until every expected result beat has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Next sample of the periodic hum; one in eight is noise or near a rail
  task automatic next_hum_sample(output logic [SAMPLE_W-1:0] v);
    int ph;
    int half;
    int ramp;
    int x;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(2))
        0:       v = SAMPLE_W'($urandom_range(19));
        1:       v = SAMPLE_W'($urandom_range(1023, 1004));
        default: v = SAMPLE_W'($urandom_range(1023));
      endcase
    end else begin
      ph = (phase_cnt + hum_offset) % hum_len;
      half = hum_len / 2;
      ramp = (ph < half) ? ph : hum_len - ph;
      x = 512 - hum_amp + (2 * hum_amp * ramp) / half;
      x = x + int'($urandom_range(2 * noise_amp)) - noise_amp;
      if (x < 0) x = 0;
      if (x > 1023) x = 1023;
      v = SAMPLE_W'(x);
    end
    // Advance the phase; drift once per period so the lag sums move
    phase_cnt++;
    if (phase_cnt >= hum_len) begin
      phase_cnt = 0;
      hum_offset = (hum_offset + hum_len + hum_drift) % hum_len;
    end
  endtask

  task automatic run_phase(input logic mode, input logic [SHIFT_W-1:0] shift,
                           input logic [PERIOD_W-1:0] len, input logic [RATE_W-1:0] rate,
                           input int beats);
    logic [SAMPLE_W-1:0] v;
    load_settings(mode, shift, len, rate);
    hum_len = int'(len);
    if (hum_len < MIN_PERIOD) hum_len = MIN_PERIOD;
    if (hum_len > STORE_DEPTH) hum_len = STORE_DEPTH;
    hum_amp = int'($urandom_range(500, 40));
    noise_amp = int'($urandom_range(60));
    hum_drift = int'($urandom_range(6)) - 3;
    hum_offset = int'($urandom_range(hum_len - 1));
    phase_cnt = 0;
    repeat (beats) begin
      next_hum_sample(v);
      send_sample(v);
    end
    settle();
  endtask

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return RATE_W'($urandom);
    endcase
  endfunction

  logic [SAMPLE_W-1:0] rail_values [9] = '{10'd0, 10'd1023, 10'd19, 10'd20, 10'd1003,
                                           10'd1004, 10'd512, 10'h155, 10'h2AA};
  logic [SAMPLE_W-1:0] swing_values [16] = '{10'd0, 10'd1023, 10'd0, 10'd1023, 10'd1,
                                             10'd1022, 10'd300, 10'd700, 10'd1023, 10'd0,
                                             10'd1023, 10'd0, 10'd511, 10'd512, 10'd20,
                                             10'd1003};

  initial begin
    int unsigned     r;
    logic [PERIOD_W-1:0] len;
    logic [SHIFT_W-1:0]  shift;
    int              beats;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SUBTRACT_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: subtract mode, period 400, rate word at all ones.
    // Rail values and both clip thresholds from each side.
    foreach (rail_values[i]) send_sample(rail_values[i]);
    settle();

    // Hum-only output, shift above the cap, period below the minimum. The
    // position is past the shortened period, so the next sample closes it.
    load_settings(1'b0, 3'd7, 10'd0, '0);
    foreach (swing_values[i]) send_sample(swing_values[i]);
    settle();

    // Random part: well-formed periodic hum with noise, settings per phase
    for (int p = 0; p < 11; p++) begin
      beats = 125;
      r = $urandom_range(9);
      if (r < 6) len = PERIOD_W'($urandom_range(48, 8));
      else if (r < 8) len = PERIOD_W'($urandom_range(160, 49));
      else if (r < 9) len = PERIOD_W'($urandom_range(7));
      else len = PERIOD_W'($urandom_range(300, 161));
      shift = SHIFT_W'($urandom_range(7));
      case (p)
        // Short periods so the averaging shift climbs to its cap
        0: begin
          len = 10'd8;
          shift = 3'd6;
          beats = 130;
        end
        // Cap lowered below the shift already reached
        1: shift = 3'd0;
        // Longest period; field above the store depth
        2: begin
          len = 10'd1023;
          shift = 3'd7;
          beats = 540;
        end
        // Shortened again while the position sits far past it
        3: len = PERIOD_W'($urandom_range(7));
        default: ;
      endcase
      run_phase(1'($urandom_range(1)), shift, len, pick_rate(), beats);
    end

    // settle() above already waited out every result plus a margin
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/hcc_pkg.sv
src/hcc_ram.sv
src/hcc_front.sv
src/hcc_queue.sv
src/hcc_back.sv
src/hum_comb_canceller.sv
sim/hcc_result_checker.sv
sim/hum_comb_canceller_tb.sv
